// ===== hdl/fsx_pkg.sv =====
// Shared types and constants for the frame sum/XOR checker.
`timescale 1ns / 1ps

package fsx_pkg;

  // Width of the saturating byte counter and its ceiling.
  localparam int unsigned CntW = 9;
  localparam logic [CntW-1:0] CntMax = 9'h1FF;

  // Verdict codes carried on the status field.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_LEN_ERR   = 3'd2,
    ST_SUM_ERR   = 3'd3,
    ST_XOR_ERR   = 3'd4
  } status_e;

  // One received byte of a frame.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

  // One verdict for a finished frame.
  typedef struct packed {
    status_e    status;
    logic [7:0] command;
    logic [7:0] length;
  } result_t;

endpackage

// ===== hdl/fsx_in_stage.sv =====
// Input register that holds one accepted byte until the checker takes it.
`timescale 1ns / 1ps

module fsx_in_stage
  import fsx_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  beat_t beat_i,
  input  logic  take_i,
  output logic  valid_o,
  output beat_t beat_o
);

  logic  vld_q;
  logic  vld_d;
  beat_t beat_q;
  logic  load;

  // The register can load when it is empty or its beat leaves this cycle.
  assign in_ready_o = !vld_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      beat_q <= beat_i;
    end
  end

  assign valid_o = vld_q;
  assign beat_o  = beat_q;

endmodule

// ===== hdl/fsx_core.sv =====
// Frame state: header capture, payload sum and XOR, check bytes, verdict.
`timescale 1ns / 1ps

module fsx_core
  import fsx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  beat_t   beat_i,
  output result_t result_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      xor_q, xor_d;
  logic [7:0]      sum_exp_q, sum_exp_d;
  logic [7:0]      xor_exp_q, xor_exp_d;
  logic [CntW:0]   idx;
  logic [CntW:0]   len_ext;
  logic [CntW:0]   cnt_ext;
  status_e         status;

  // Absorb the byte according to its place in the frame.
  always_comb begin
    cmd_d     = cmd_q;
    len_d     = len_q;
    sum_d     = sum_q;
    xor_d     = xor_q;
    sum_exp_d = sum_exp_q;
    xor_exp_d = xor_exp_q;
    idx       = {1'b0, cnt_q};
    len_ext   = {{(CntW-7){1'b0}}, len_q};
    if (cnt_q == CntW'(0)) begin
      cmd_d = beat_i.data;
    end else if (cnt_q == CntW'(1)) begin
      len_d = beat_i.data;
    end else if (idx < len_ext + (CntW+1)'(2)) begin
      sum_d = sum_q + beat_i.data;
      xor_d = xor_q ^ beat_i.data;
    end else if (idx == len_ext + (CntW+1)'(2)) begin
      sum_exp_d = beat_i.data;
    end else if (idx == len_ext + (CntW+1)'(3)) begin
      xor_exp_d = beat_i.data;
    end
    cnt_d = (cnt_q == CntMax) ? cnt_q : cnt_q + CntW'(1);
  end

  // Verdict formed from the state with this byte included.
  assign cnt_ext = {1'b0, cnt_d};

  always_comb begin
    if (cnt_d <= CntW'(2)) begin
      status = ST_TOO_SHORT;
    end else if (cnt_ext < {{(CntW-7){1'b0}}, len_d} + (CntW+1)'(4)) begin
      status = ST_LEN_ERR;
    end else if (sum_d != sum_exp_d) begin
      status = ST_SUM_ERR;
    end else if (xor_d != xor_exp_d) begin
      status = ST_XOR_ERR;
    end else begin
      status = ST_OK;
    end
  end

  assign result_o.status  = status;
  assign result_o.command = cmd_d;
  assign result_o.length  = len_d;

  // State registers; a final byte returns everything to the reset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmd_q     <= '0;
      len_q     <= '0;
      sum_q     <= '0;
      xor_q     <= '0;
      sum_exp_q <= '0;
      xor_exp_q <= '0;
    end else if (fire_i) begin
      if (beat_i.last) begin
        cnt_q     <= '0;
        cmd_q     <= '0;
        len_q     <= '0;
        sum_q     <= '0;
        xor_q     <= '0;
        sum_exp_q <= '0;
        xor_exp_q <= '0;
      end else begin
        cnt_q     <= cnt_d;
        cmd_q     <= cmd_d;
        len_q     <= len_d;
        sum_q     <= sum_d;
        xor_q     <= xor_d;
        sum_exp_q <= sum_exp_d;
        xor_exp_q <= xor_exp_d;
      end
    end
  end

endmodule

// ===== hdl/fsx_out_stage.sv =====
// Result register that holds one verdict until the consumer takes it.
`timescale 1ns / 1ps

module fsx_out_stage
  import fsx_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    can_load_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t result_o
);

  logic    vld_q;
  logic    vld_d;
  result_t res_q;

  // A new verdict may enter when the register is empty or being drained.
  assign can_load_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = vld_q;
  assign result_o    = res_q;

endmodule

// ===== hdl/frame_sum_xor_checker_unit.sv =====
// Top level of the length-prefixed frame checker with sum and XOR check bytes.
`timescale 1ns / 1ps

// Checks one command frame fed one byte per beat, command byte first, then the
// payload length L, L payload bytes, a sum check byte and an XOR check byte;
// bytes after that are ignored. The beat flagged last yields one verdict
// (too short, length error, sum mismatch, xor mismatch in that priority, else
// ok) with the command code and length byte; other beats yield nothing. The
// block takes one byte per clock cycle unless a last byte waits for a full
// result register. A last byte passes the input register, and its verdict is
// held in the result register until taken. A held verdict stalls only the next
// last byte; ordinary bytes keep flowing into the frame state.

module frame_sum_xor_checker_unit
  import fsx_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [7:0] command_code_o,
  output logic [7:0] payload_length_o
);

  beat_t   in_beat;
  beat_t   cur_beat;
  logic    cur_valid;
  logic    out_can_load;
  logic    fire;
  result_t verdict;
  result_t out_res;

  assign in_beat.data = data_byte_i;
  assign in_beat.last = last_byte_i;

  // A byte advances unless it is a last byte and the result register is full.
  assign fire = cur_valid && (!cur_beat.last || out_can_load);

  fsx_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .beat_i     (in_beat),
    .take_i     (fire),
    .valid_o    (cur_valid),
    .beat_o     (cur_beat)
  );

  fsx_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .beat_i   (cur_beat),
    .result_o (verdict)
  );

  fsx_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && cur_beat.last),
    .result_i    (verdict),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_res)
  );

  assign status_o         = out_res.status;
  assign command_code_o   = out_res.command;
  assign payload_length_o = out_res.length;

endmodule
